>>> hdl/cbpf_pkg.sv
// ----------------------------------------------------------------------------
// cbpf_pkg
// Shared types and constants of the classic BPF filter engine.
// ----------------------------------------------------------------------------
`default_nettype none
package cbpf_pkg;

  localparam logic [1:0] CMD_WRITE_SLOT = 2'd0;
  localparam logic [1:0] CMD_WRITE_DATA = 2'd1;
  localparam logic [1:0] CMD_RUN        = 2'd2;

  localparam logic [31:0] FAULT_VALUE  = 32'h8000_0000;
  localparam logic [31:0] RECORD_BYTES = 32'd64;

  localparam logic [15:0] OP_LD_ABS  = 16'h0020;
  localparam logic [15:0] OP_LD_LEN  = 16'h0080;
  localparam logic [15:0] OP_LDX_LEN = 16'h0081;
  localparam logic [15:0] OP_LD_IMM  = 16'h0000;
  localparam logic [15:0] OP_LDX_IMM = 16'h0001;
  localparam logic [15:0] OP_LD_MEM  = 16'h0060;
  localparam logic [15:0] OP_LDX_MEM = 16'h0061;
  localparam logic [15:0] OP_ST      = 16'h0002;
  localparam logic [15:0] OP_STX     = 16'h0003;
  localparam logic [15:0] OP_TAX     = 16'h0007;
  localparam logic [15:0] OP_TXA     = 16'h0087;
  localparam logic [15:0] OP_ADD_K   = 16'h0004;
  localparam logic [15:0] OP_ADD_X   = 16'h000c;
  localparam logic [15:0] OP_SUB_K   = 16'h0014;
  localparam logic [15:0] OP_SUB_X   = 16'h001c;
  localparam logic [15:0] OP_MUL_K   = 16'h0024;
  localparam logic [15:0] OP_MUL_X   = 16'h002c;
  localparam logic [15:0] OP_DIV_K   = 16'h0034;
  localparam logic [15:0] OP_DIV_X   = 16'h003c;
  localparam logic [15:0] OP_OR_K    = 16'h0044;
  localparam logic [15:0] OP_OR_X    = 16'h004c;
  localparam logic [15:0] OP_AND_K   = 16'h0054;
  localparam logic [15:0] OP_AND_X   = 16'h005c;
  localparam logic [15:0] OP_LSH_K   = 16'h0064;
  localparam logic [15:0] OP_LSH_X   = 16'h006c;
  localparam logic [15:0] OP_RSH_K   = 16'h0074;
  localparam logic [15:0] OP_RSH_X   = 16'h007c;
  localparam logic [15:0] OP_NEG     = 16'h0084;
  localparam logic [15:0] OP_XOR_K   = 16'h00a4;
  localparam logic [15:0] OP_XOR_X   = 16'h00ac;
  localparam logic [15:0] OP_JA      = 16'h0005;
  localparam logic [15:0] OP_JEQ_K   = 16'h0015;
  localparam logic [15:0] OP_JEQ_X   = 16'h001d;
  localparam logic [15:0] OP_JGT_K   = 16'h0025;
  localparam logic [15:0] OP_JGT_X   = 16'h002d;
  localparam logic [15:0] OP_JGE_K   = 16'h0035;
  localparam logic [15:0] OP_JGE_X   = 16'h003d;
  localparam logic [15:0] OP_JSET_K  = 16'h0045;
  localparam logic [15:0] OP_JSET_X  = 16'h004d;
  localparam logic [15:0] OP_RET_K   = 16'h0006;
  localparam logic [15:0] OP_RET_A   = 16'h0016;

  // controller -> datapath
  typedef struct packed {
    logic clear;      // start of run: clear A, X, scratch
    logic fetch;      // register instruction from program RAM
    logic exec;       // execute the fetched instruction
    logic div_start;
    logic div_done;   // write quotient to A
  } cbpf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic        pc_over;   // next pc past store
    logic        is_ret;
    logic        is_div;
    logic        div_zero;
    logic        bad_op;
    logic        ld_over;
    logic        div_busy;
    logic [31:0] ret_val;
  } cbpf_stat_t;

endpackage
`default_nettype wire

>>> hdl/classic_bpf_filter_engine.sv
// ----------------------------------------------------------------------------
// classic_bpf_filter_engine
// Classic BPF interpreter (seccomp subset) over a 16-word call record.
// ----------------------------------------------------------------------------
//  channel  ports                                   direction
//  in       in_valid/in_stall, in_cmd .. in_data_word  input
//  out      out_valid/out_stall, out_return_value, out_fault  output
//
//  Each instruction of a run is a program RAM fetch, then an execute; a divide
//  adds a wait on the divider before the quotient is written to A.
//  Synchronous active-low reset clears the call record and control state;
//  program slots are undefined until written.
//  in_stall is high during a run and while a result waits on out_stall.
`default_nettype none
module classic_bpf_filter_engine #(
  parameter int PROGRAM_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [11:0] in_slot,
  input  wire logic [15:0] in_opcode,
  input  wire logic [7:0]  in_jump_true,
  input  wire logic [7:0]  in_jump_false,
  input  wire logic [31:0] in_operand,
  input  wire logic [31:0] in_data_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_return_value,
  output logic             out_fault
);
  cbpf_pkg::cbpf_cmd_t  cmd;
  cbpf_pkg::cbpf_stat_t stat;

  cbpf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_cmd),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .out_return_value(out_return_value), .out_fault(out_fault),
    .stat(stat), .cmd(cmd)
  );

  cbpf_datapath #(.PROGRAM_DEPTH(PROGRAM_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .load_we(in_valid && !in_stall),
    .load_cmd(in_cmd), .load_slot(in_slot), .load_opcode(in_opcode),
    .load_jt(in_jump_true), .load_jf(in_jump_false), .load_k(in_operand),
    .load_data(in_data_word), .cmd(cmd), .stat(stat)
  );

  a_fault_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_return_value == cbpf_pkg::FAULT_VALUE)
    else $error("fault without fault value");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> in_stall)
    else $error("input accepted during run");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.exec, cmd.div_start, cmd.div_done}))
    else $error("conflicting datapath commands");
endmodule
`default_nettype wire

>>> hdl/cbpf_ram.sv
// ----------------------------------------------------------------------------
// cbpf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/cbpf_div.sv
// ----------------------------------------------------------------------------
// cbpf_div
// Radix-2 restoring divider; busy while the 32 quotient bits are formed.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpf_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [31:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;

  assign trial    = {rem_r, q_r[31]} - {1'b0, d_r};
  assign busy     = cnt_r != 6'd0;
  assign quotient = q_r;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd32;
    end else if (busy) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end
endmodule
`default_nettype wire

>>> hdl/cbpf_datapath.sv
// ----------------------------------------------------------------------------
// cbpf_datapath
// Program store, call record, registers, ALU and branch logic.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpf_datapath #(
  parameter int PROGRAM_DEPTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load_we,
  input  wire logic [1:0]           load_cmd,
  input  wire logic [11:0]          load_slot,
  input  wire logic [15:0]          load_opcode,
  input  wire logic [7:0]           load_jt,
  input  wire logic [7:0]           load_jf,
  input  wire logic [31:0]          load_k,
  input  wire logic [31:0]          load_data,
  input  wire cbpf_pkg::cbpf_cmd_t  cmd,
  output cbpf_pkg::cbpf_stat_t      stat
);
  localparam int AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;

  logic [31:0] data_r [16];
  logic [31:0] scr_r [16];
  logic [31:0] a_r, a_nxt, x_r, x_nxt;
  logic [12:0] pc_r, pc_nxt;
  logic [63:0] ins;
  logic [15:0] op;
  logic [7:0]  jt, jf;
  logic [31:0] k, rhs;
  logic        prog_we, cond;
  logic [AW-1:0] raddr;
  logic        div_busy;
  logic [31:0] quot;
  logic [63:0] mul_full;
  logic [13:0] ja_sum;

  assign prog_we = load_we && load_cmd == cbpf_pkg::CMD_WRITE_SLOT &&
                   {1'b0, load_slot} < 13'(PROGRAM_DEPTH);
  assign raddr   = pc_r[AW-1:0];

  cbpf_ram #(.WIDTH(64), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk(clk), .we(prog_we), .waddr(load_slot[AW-1:0]),
    .wdata({load_opcode, load_jt, load_jf, load_k}),
    .raddr(raddr), .rdata(ins)
  );

  cbpf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(a_r),
    .divisor(op[3] ? x_r : k), .busy(div_busy), .quotient(quot)
  );

  assign op  = ins[63:48];
  assign jt  = ins[47:40];
  assign jf  = ins[39:32];
  assign k   = ins[31:0];
  assign rhs = op[3] ? x_r : k;
  assign mul_full = a_r * rhs;
  assign ja_sum   = {1'b0, pc_r} + 14'd1 + {1'b0, k[12:0]};

  always_comb begin
    case (op[7:4])
      4'h1:    cond = a_r == rhs;
      4'h2:    cond = a_r > rhs;
      4'h3:    cond = a_r >= rhs;
      default: cond = (a_r & rhs) != 32'd0;
    endcase
  end

  always_comb begin
    a_nxt  = a_r;
    x_nxt  = x_r;
    pc_nxt = pc_r + 13'd1;
    stat   = '0;
    stat.div_busy = div_busy;
    stat.ret_val  = (op == cbpf_pkg::OP_RET_K) ? k : a_r;
    case (op)
      cbpf_pkg::OP_LD_ABS: begin
        stat.ld_over = k >= cbpf_pkg::RECORD_BYTES;
        a_nxt = data_r[k[5:2]];
      end
      cbpf_pkg::OP_LD_LEN:  a_nxt = cbpf_pkg::RECORD_BYTES;
      cbpf_pkg::OP_LDX_LEN: x_nxt = cbpf_pkg::RECORD_BYTES;
      cbpf_pkg::OP_LD_IMM:  a_nxt = k;
      cbpf_pkg::OP_LDX_IMM: x_nxt = k;
      cbpf_pkg::OP_LD_MEM:  a_nxt = scr_r[k[3:0]];
      cbpf_pkg::OP_LDX_MEM: x_nxt = scr_r[k[3:0]];
      cbpf_pkg::OP_ST, cbpf_pkg::OP_STX: ;
      cbpf_pkg::OP_TAX: x_nxt = a_r;
      cbpf_pkg::OP_TXA: a_nxt = x_r;
      cbpf_pkg::OP_ADD_K, cbpf_pkg::OP_ADD_X: a_nxt = a_r + rhs;
      cbpf_pkg::OP_SUB_K, cbpf_pkg::OP_SUB_X: a_nxt = a_r - rhs;
      cbpf_pkg::OP_MUL_K, cbpf_pkg::OP_MUL_X: a_nxt = mul_full[31:0];
      cbpf_pkg::OP_DIV_K, cbpf_pkg::OP_DIV_X: begin
        stat.is_div   = 1'b1;
        stat.div_zero = rhs == 32'd0;
      end
      cbpf_pkg::OP_OR_K,  cbpf_pkg::OP_OR_X:  a_nxt = a_r | rhs;
      cbpf_pkg::OP_AND_K, cbpf_pkg::OP_AND_X: a_nxt = a_r & rhs;
      cbpf_pkg::OP_LSH_K, cbpf_pkg::OP_LSH_X: a_nxt = a_r << rhs[4:0];
      cbpf_pkg::OP_RSH_K, cbpf_pkg::OP_RSH_X: a_nxt = a_r >> rhs[4:0];
      cbpf_pkg::OP_NEG: a_nxt = 32'd0 - a_r;
      cbpf_pkg::OP_XOR_K, cbpf_pkg::OP_XOR_X: a_nxt = a_r ^ rhs;
      // any target past the 13-bit pc range pins to 0x1000 so the overrun check sees it
      cbpf_pkg::OP_JA: pc_nxt = (k[31:13] != 19'd0 || ja_sum[13]) ? 13'h1000 :
                                ja_sum[12:0];
      cbpf_pkg::OP_JEQ_K, cbpf_pkg::OP_JEQ_X, cbpf_pkg::OP_JGT_K, cbpf_pkg::OP_JGT_X,
      cbpf_pkg::OP_JGE_K, cbpf_pkg::OP_JGE_X, cbpf_pkg::OP_JSET_K, cbpf_pkg::OP_JSET_X:
        pc_nxt = pc_r + 13'd1 + {5'd0, cond ? jt : jf};
      cbpf_pkg::OP_RET_K, cbpf_pkg::OP_RET_A: stat.is_ret = 1'b1;
      default: stat.bad_op = 1'b1;
    endcase
    stat.pc_over = pc_nxt >= 13'(PROGRAM_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) data_r[i] <= '0;
    end else if (load_we && load_cmd == cbpf_pkg::CMD_WRITE_DATA) begin
      data_r[load_slot[3:0]] <= load_data;
    end
    if (cmd.clear) begin
      a_r  <= '0;
      x_r  <= '0;
      pc_r <= '0;
      for (int i = 0; i < 16; i++) scr_r[i] <= '0;
    end else if (cmd.div_done) begin
      a_r  <= quot;
      pc_r <= pc_r + 13'd1;
    end else if (cmd.exec) begin
      a_r  <= a_nxt;
      x_r  <= x_nxt;
      pc_r <= pc_nxt;
      if (op == cbpf_pkg::OP_ST)  scr_r[k[3:0]] <= a_r;
      if (op == cbpf_pkg::OP_STX) scr_r[k[3:0]] <= x_r;
    end
  end
endmodule
`default_nettype wire

>>> hdl/cbpf_ctrl.sv
// ----------------------------------------------------------------------------
// cbpf_ctrl
// Run sequencer: fetch, execute, divide wait, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_cmd,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [31:0]               out_return_value,
  output logic                      out_fault,
  input  wire cbpf_pkg::cbpf_stat_t stat,
  output cbpf_pkg::cbpf_cmd_t       cmd
);
  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_DIV, S_DIVEND} state_t;
  state_t state_r;
  logic accept, fin;
  logic [31:0] val;
  logic flt;

  assign in_stall = state_r != S_IDLE || out_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    fin = 1'b0;
    val = '0;
    flt = 1'b0;
    cmd.clear = accept && in_cmd == cbpf_pkg::CMD_RUN;
    case (state_r)
      S_EXEC: begin
        if (stat.bad_op) begin
          fin = 1'b1; val = cbpf_pkg::FAULT_VALUE; flt = 1'b1;
        end else if (stat.is_ret) begin
          fin = 1'b1; val = stat.ret_val;
        end else if (stat.ld_over || (stat.is_div && stat.div_zero)) begin
          fin = 1'b1;
        end else if (stat.pc_over) begin
          fin = 1'b1; val = cbpf_pkg::FAULT_VALUE; flt = 1'b1;
        end else if (stat.is_div) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.exec = 1'b1;
        end
      end
      S_DIV: if (!stat.div_busy) cmd.div_done = 1'b1;
      default: ;
    endcase
    cmd.fetch = state_r == S_FETCH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE:  if (cmd.clear) state_r <= S_FETCH;
        S_FETCH: state_r <= S_EXEC;
        S_EXEC: begin
          if (fin) begin
            state_r          <= S_IDLE;
            out_valid        <= 1'b1;
            out_return_value <= val;
            out_fault        <= flt;
          end else if (cmd.div_start) state_r <= S_DIV;
          else state_r <= S_FETCH;
        end
        S_DIV:    if (cmd.div_done) state_r <= S_DIVEND;
        S_DIVEND: state_r <= S_FETCH;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> bench/classic_bpf_filter_engine_checker.sv
// ----------------------------------------------------------------------------
// classic_bpf_filter_engine_checker
// Watches both channels of the filter engine. It keeps its own copy of the
// program store and call record, interprets every run transaction, queues
// the predicted return and compares each result transaction with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module classic_bpf_filter_engine_checker
  import cbpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [11:0] in_slot,
  input  wire logic [15:0] in_opcode,
  input  wire logic [7:0]  in_jump_true,
  input  wire logic [7:0]  in_jump_false,
  input  wire logic [31:0] in_operand,
  input  wire logic [31:0] in_data_word,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_return_value,
  input  wire logic        out_fault,
  output int               fail_count,
  output int               pending,
  output int               faults_seen
);

  localparam int DEPTH = 4096;

  typedef struct packed {
    logic [31:0] return_value;
    logic        fault;
  } verdict_t;

  logic [15:0] prog_op [DEPTH];
  logic [7:0]  prog_jt [DEPTH];
  logic [7:0]  prog_jf [DEPTH];
  logic [31:0] prog_k  [DEPTH];
  logic [31:0] record  [16];
  verdict_t    returns_due [$];

  function automatic verdict_t run_filter();
    logic [31:0] acc;
    logic [31:0] idx;
    logic [31:0] k;
    logic [31:0] rhs;
    logic [31:0] scr [16];
    logic [33:0] at;
    logic [33:0] nxt;
    logic [15:0] op;
    logic        cond;
    int          guard;
    acc = '0;
    idx = '0;
    at  = '0;
    foreach (scr[i]) scr[i] = '0;
    for (guard = 0; guard < DEPTH + 2; guard++) begin
      if (at >= DEPTH) return '{FAULT_VALUE, 1'b1};
      op   = prog_op[at[11:0]];
      k    = prog_k[at[11:0]];
      rhs  = op[3] ? idx : k;
      nxt  = at + 34'd1;
      cond = 1'b0;
      case (op)
        OP_LD_ABS: begin
          if (k >= RECORD_BYTES) return '{32'd0, 1'b0};
          acc = record[k[5:2]];
        end
        OP_LD_LEN:  acc = RECORD_BYTES;
        OP_LDX_LEN: idx = RECORD_BYTES;
        OP_LD_IMM:  acc = k;
        OP_LDX_IMM: idx = k;
        OP_LD_MEM:  acc = scr[k[3:0]];
        OP_LDX_MEM: idx = scr[k[3:0]];
        OP_ST:      scr[k[3:0]] = acc;
        OP_STX:     scr[k[3:0]] = idx;
        OP_TAX:     idx = acc;
        OP_TXA:     acc = idx;
        OP_ADD_K, OP_ADD_X: acc = acc + rhs;
        OP_SUB_K, OP_SUB_X: acc = acc - rhs;
        OP_MUL_K, OP_MUL_X: acc = acc * rhs;
        OP_DIV_K, OP_DIV_X: begin
          if (rhs == 0) return '{32'd0, 1'b0};
          acc = acc / rhs;
        end
        OP_OR_K, OP_OR_X:   acc = acc | rhs;
        OP_AND_K, OP_AND_X: acc = acc & rhs;
        OP_LSH_K, OP_LSH_X: acc = acc << rhs[4:0];
        OP_RSH_K, OP_RSH_X: acc = acc >> rhs[4:0];
        OP_NEG:             acc = 32'd0 - acc;
        OP_XOR_K, OP_XOR_X: acc = acc ^ rhs;
        OP_JA:              nxt = nxt + {2'b00, k};
        OP_JEQ_K, OP_JEQ_X, OP_JGT_K, OP_JGT_X,
        OP_JGE_K, OP_JGE_X, OP_JSET_K, OP_JSET_X: begin
          case (op)
            OP_JEQ_K, OP_JEQ_X: cond = (acc == rhs);
            OP_JGT_K, OP_JGT_X: cond = (acc > rhs);
            OP_JGE_K, OP_JGE_X: cond = (acc >= rhs);
            default:            cond = ((acc & rhs) != 0);
          endcase
          nxt = nxt + (cond ? prog_jt[at[11:0]] : prog_jf[at[11:0]]);
        end
        OP_RET_K: return '{k, 1'b0};
        OP_RET_A: return '{acc, 1'b0};
        default:  return '{FAULT_VALUE, 1'b1};
      endcase
      at = nxt;
    end
    return '{FAULT_VALUE, 1'b1};
  endfunction

  initial begin
    fail_count  = 0;
    faults_seen = 0;
    foreach (record[i]) record[i] = '0;
    foreach (prog_op[i]) begin
      prog_op[i] = '0;
      prog_jt[i] = '0;
      prog_jf[i] = '0;
      prog_k[i]  = '0;
    end
  end

  assign pending = returns_due.size();

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (returns_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result value=%h fault=%b",
                     $realtime, out_return_value, out_fault);
        end else begin
          want = returns_due.pop_front();
          if (out_fault) faults_seen++;
          if (want.return_value !== out_return_value || want.fault !== out_fault) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch value exp=%h got=%h fault exp=%b got=%b",
                       $realtime, want.return_value, out_return_value,
                       want.fault, out_fault);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_cmd)
          CMD_WRITE_SLOT: begin
            prog_op[in_slot] = in_opcode;
            prog_jt[in_slot] = in_jump_true;
            prog_jf[in_slot] = in_jump_false;
            prog_k[in_slot]  = in_operand;
          end
          CMD_WRITE_DATA: record[in_slot[3:0]] = in_data_word;
          CMD_RUN:        returns_due.push_back(run_filter());
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> bench/classic_bpf_filter_engine_tb.sv
// ----------------------------------------------------------------------------
// classic_bpf_filter_engine_tb
// Stimulus and verdict for the filter engine. Directed programs hit the
// record bounds, zero divides, bad opcodes and counter overrun; then random
// programs, placed low with in-range jumps or high against the end of the
// store, run under three idle profiles with one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module classic_bpf_filter_engine_tb;
  import cbpf_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int ITEM_TARGET = 1000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  localparam logic [15:0] OP_LIST [41] = '{
    OP_LD_ABS, OP_LD_LEN, OP_LDX_LEN, OP_LD_IMM, OP_LDX_IMM, OP_LD_MEM,
    OP_LDX_MEM, OP_ST, OP_STX, OP_TAX, OP_TXA, OP_ADD_K, OP_ADD_X,
    OP_SUB_K, OP_SUB_X, OP_MUL_K, OP_MUL_X, OP_DIV_K, OP_DIV_X, OP_OR_K,
    OP_OR_X, OP_AND_K, OP_AND_X, OP_LSH_K, OP_LSH_X, OP_RSH_K, OP_RSH_X,
    OP_NEG, OP_XOR_K, OP_XOR_X, OP_JA, OP_JEQ_K, OP_JEQ_X, OP_JGT_K,
    OP_JGT_X, OP_JGE_K, OP_JGE_X, OP_JSET_K, OP_JSET_X, OP_RET_K, OP_RET_A
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [11:0] in_slot = '0;
  logic [15:0] in_opcode = '0;
  logic [7:0]  in_jump_true = '0;
  logic [7:0]  in_jump_false = '0;
  logic [31:0] in_operand = '0;
  logic [31:0] in_data_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_return_value;
  logic        out_fault;

  int fail_count;
  int pending;
  int faults_seen;
  int cycles = 0;
  int items_sent = 0;
  int runs_sent = 0;
  int send_pct = 0;
  int recv_pct = 0;
  bit hold_pending = 1'b0;

  always #5 clk = ~clk;

  classic_bpf_filter_engine uut (.*);

  classic_bpf_filter_engine_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("** classic_bpf_filter_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    forever begin
      if (hold_pending) begin
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_pending = 1'b0;
      end
      out_stall <= rst_n && ($urandom_range(99) < recv_pct);
      @(negedge clk);
    end
  end

  task automatic put(input logic [1:0] cmd, input logic [11:0] slot,
                     input logic [15:0] op, input logic [7:0] jt,
                     input logic [7:0] jf, input logic [31:0] k,
                     input logic [31:0] dw);
    int gap;
    gap = ($urandom_range(99) < send_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_slot       <= slot;
    in_opcode     <= op;
    in_jump_true  <= jt;
    in_jump_false <= jf;
    in_operand    <= k;
    in_data_word  <= dw;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (cmd != 2'd3) items_sent++;
    if (cmd == CMD_RUN) runs_sent++;
  endtask

  task automatic put_slot(input logic [11:0] slot, input logic [15:0] op,
                          input logic [7:0] jt, input logic [7:0] jf,
                          input logic [31:0] k);
    put(CMD_WRITE_SLOT, slot, op, jt, jf, k, $urandom);
  endtask

  task automatic put_run();
    put(CMD_RUN, 12'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
        $urandom, $urandom);
  endtask

  // low programs keep every jump inside the written slots; high programs
  // end at the top of the store so any jump lands inside or overruns
  task automatic random_program();
    int          len;
    int          base;
    int          room;
    bit          high;
    logic [15:0] op;
    logic [31:0] k;
    logic [7:0]  jt;
    logic [7:0]  jf;
    high = ($urandom_range(99) < 20);
    len  = (high && $urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    base = high ? DEPTH - len : 0;
    if (high) put_slot(12'd0, OP_JA, 8'($urandom), 8'($urandom), 32'(base - 1));
    for (int i = 0; i < len; i++) begin
      room = len - 2 - i;
      op = ($urandom_range(99) < 5) ? 16'($urandom) : OP_LIST[$urandom_range(40)];
      k  = $urandom;
      jt = 8'($urandom);
      jf = 8'($urandom);
      if (op == OP_LD_ABS && $urandom_range(9) < 8) k = $urandom_range(63);
      if ((op == OP_DIV_K || op == OP_DIV_X) && $urandom_range(3) == 0) k = 0;
      if (!high) begin
        if (room < 0) begin
          op = $urandom_range(1) ? OP_RET_K : OP_RET_A;
        end else begin
          jt = 8'($urandom_range(room));
          jf = 8'($urandom_range(room));
          if (op == OP_JA) k = $urandom_range(room);
        end
      end
      put_slot(12'(base + i), op, jt, jf, k);
      if ($urandom_range(9) == 0)
        put(CMD_WRITE_DATA, 12'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
            $urandom, $urandom_range(1) ? $urandom : 32'($urandom_range(3)));
      if ($urandom_range(29) == 0)
        put(2'd3, 12'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
            $urandom, $urandom);
    end
    put_run();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // record extremes, then load past the record and divide by zero index
    put(CMD_WRITE_DATA, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put(CMD_WRITE_DATA, 12'h000, 16'h0000, 8'h00, 8'h00, 32'h0, 32'h0);
    put_slot(12'd0, OP_LD_ABS, 8'h00, 8'h00, 32'd60);
    put_slot(12'd1, OP_DIV_X, 8'h00, 8'h00, 32'd0);
    put_run();
    put_slot(12'd0, OP_LD_ABS, 8'h00, 8'h00, 32'd64);
    put_run();
    // unknown opcode
    put_slot(12'd0, 16'hFFFF, 8'h00, 8'h00, 32'd0);
    put_run();
    // fall off the end of the store
    put_slot(12'hFFF, OP_LD_LEN, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    put_slot(12'd0, OP_JA, 8'h00, 8'h00, 32'd4094);
    put_run();
    // conditional jump past the store
    put_slot(12'hFFE, OP_JEQ_K, 8'hFF, 8'hFF, 32'd0);
    put_slot(12'd0, OP_JA, 8'h00, 8'h00, 32'd4093);
    put_run();
    // shift by low five bits of an all-ones constant
    put_slot(12'd0, OP_LD_IMM, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    put_slot(12'd1, OP_RSH_K, 8'h00, 8'h00, 32'hFFFF_FFFF);
    put_slot(12'd2, OP_RET_A, 8'h00, 8'h00, 32'd0);
    put_run();
    put_slot(12'd0, OP_RET_K, 8'h00, 8'h00, 32'hFFFF_FFFF);
    put_run();

    send_pct = 16;
    recv_pct = 49;
    hold_pending = 1'b1;
    repeat (3) random_program();
    in_valid <= 1'b0;
    wait (pending == 0 && !hold_pending);
    @(negedge clk);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET / 3 && items_sent <= 2 * ITEM_TARGET / 3) begin
        send_pct = 49;
        recv_pct = 16;
      end else if (items_sent > 2 * ITEM_TARGET / 3) begin
        send_pct = 0;
        recv_pct = 0;
      end
      random_program();
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(negedge clk);
    $display("covered %0d load/run transactions, %0d filter runs (%0d faulted)",
             items_sent, runs_sent, faults_seen);
    $display("three idle profiles plus a %0d-cycle output hold; %0d failures",
             HOLD_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("** classic_bpf_filter_engine: PASSED **");
    end else begin
      $display("** classic_bpf_filter_engine: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
